### rtl/core/odo_pkg.sv
// Shared types, constants and helpers for the odometer core.
`timescale 1ns / 1ps

package odo_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ACC_W      = 58;
  localparam int DIST_W     = 40;
  localparam int RPM_W      = 16;
  localparam int RPM_SUM_W  = 18;
  localparam int CIRC_W     = 14;
  localparam int TIME_W     = 32;
  localparam int SEQ_W      = 32;
  localparam int REM_W      = 18;
  localparam int DIV_STEPS  = DIST_W / 2;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [REM_W-1:0]  MM_DIVISOR = 18'd240000;
  localparam logic [ACC_W-1:0]  ACC_MAX    = 58'd239999999999999999;
  localparam logic [DIST_W-1:0] DIST_LIMIT = 40'd1000000000000;

  localparam logic [CIRC_W-1:0] CIRC_RESET     = 14'd1600;
  localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd300000;

  localparam logic [CFG_ADDR_W-1:0] REG_CIRC     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL = 1'b1;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic [TIME_W-1:0]       time_ms;
    logic                    drive_ready;
    logic signed [RPM_W-1:0] rpm_front_left;
    logic signed [RPM_W-1:0] rpm_front_right;
    logic signed [RPM_W-1:0] rpm_rear_left;
    logic signed [RPM_W-1:0] rpm_rear_right;
    logic [2:0]              record_slot;
    logic [DIST_W-1:0]       record_distance_mm;
    logic [SEQ_W-1:0]        record_sequence;
  } in_word_t;

  typedef struct packed {
    logic              save_request;
    logic [2:0]        save_slot;
    logic [SEQ_W-1:0]  save_sequence;
    logic [DIST_W-1:0] save_distance_mm;
    logic [DIST_W-1:0] total_distance_mm;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic acc;
    logic div_step;
    logic finish;
  } odo_cmd_t;

  typedef struct packed {
    logic out_free;
  } odo_status_t;

  // Stored slot index folded into the slot range
  function automatic logic [SLOT_W-1:0] slot_mod(input logic [2:0] s);
    logic [8:0] v;
    v = 9'(s);
    for (int i = 0; i < 4; i++) begin
      if (v >= 9'(NUM_SLOTS)) begin
        v = v - 9'(NUM_SLOTS);
      end
    end
    return SLOT_W'(v);
  endfunction

endpackage

### rtl/core/odometer_accumulator_with_slot_log_core.sv
// Top level of the odometer accumulator with rotating save-slot log.
`timescale 1ns / 1ps
//
// One input word per call: an update tick (wheel rpms, time stamp, ready flag)
// or a stored record offered at boot. Every input word yields exactly one
// output word carrying the current distance and, when due, a save request
// with slot, sequence and distance to write.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// Configuration writes (circumference, save interval) go through cfg_we,
// cfg_addr and cfg_wdata and take effect at once; write them while idle.
// Sequence: an update tick while ready to drive passes from accept through two
// multiply stages, accumulate, 20 radix-4 divider steps by 240000 and finish
// into the output register; any other word goes from accept straight to
// finish. The input is stalled while a word is in work, so no new word is
// taken until the last one has finished. A finished word waits in the output
// register while the receiver stalls; the next word is accepted meanwhile but
// cannot finish until that register is free.
// Reset (synchronous, rst_n low) clears distance, sequence, slot and the
// boot-record flag and restores the configuration defaults.

module odometer_accumulator_with_slot_log_core import odo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  odo_cmd_t    cmd;
  odo_status_t status;

  odo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  odo_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

### rtl/core/odo_ctrl.sv
// Sequencing state machine for the odometer core.
`timescale 1ns / 1ps

module odo_ctrl import odo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  in_word_t    in_word,
  output logic        in_stall,
  input  odo_status_t status,
  output odo_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_word.opcode == OP_UPDATE && in_word.drive_ready) begin
            state_nxt = S_MUL1;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_W'(DIV_STEPS - 1)) |=> (state_r == S_FIN))
    else $error("divider did not hand over to finish");

  a_fin_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !status.out_free) |=> (state_r == S_FIN))
    else $error("left finish while output register full");

  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r <= S_FIN)
    else $error("state register holds an unused code");

endmodule

### rtl/core/odo_dpath.sv
// Datapath: accumulator, multipliers, radix-4 divider, save log and output register.
`timescale 1ns / 1ps

module odo_dpath import odo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_word_t              in_word,
  input  odo_cmd_t              cmd,
  output odo_status_t           status,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word
);

  // configuration
  logic [CIRC_W-1:0] circ_r;
  logic [TIME_W-1:0] interval_r;

  // architectural state
  logic              was_ready_r;
  logic [TIME_W-1:0] last_update_r;
  logic [TIME_W-1:0] last_save_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SEQ_W-1:0]  seq_cnt_r;
  logic              found_r;
  logic [DIST_W-1:0] dist_r, dist_nxt;

  // working registers
  in_word_t          item_r;
  logic              neg_r;
  logic [31:0]       prod1_r;
  logic [TIME_W-1:0] dt_r;
  logic [ACC_W-1:0]  delta_r;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DIST_W-1:0] dvd_r;
  logic [DIST_W-1:0] quo_r;
  logic [1:0]        qbits;

  logic              out_valid_r;
  out_word_t         out_word_r, out_word_nxt;

  logic signed [RPM_SUM_W-1:0] rpm_sum;
  logic [RPM_SUM_W-1:0]        mag;
  logic [63:0]                 prod2;
  logic [ACC_W:0]              acc_sum;
  logic [ACC_W-1:0]            acc_upd;
  logic [REM_W+1:0]            trial;
  logic                        is_upd, ready, do_save, take;
  logic [TIME_W-1:0]           since_save;
  logic [SLOT_W-1:0]           slot_inc;
  logic [ACC_W-1:0]            rec_x15;
  logic [ACC_W-1:0]            rec_acc;

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_word        = out_word_r;

  always_comb begin
    rpm_sum = RPM_SUM_W'(item_r.rpm_front_left) + RPM_SUM_W'(item_r.rpm_front_right)
            + RPM_SUM_W'(item_r.rpm_rear_left) + RPM_SUM_W'(item_r.rpm_rear_right);
    mag     = rpm_sum[RPM_SUM_W-1] ? RPM_SUM_W'(-rpm_sum) : RPM_SUM_W'(rpm_sum);
  end

  assign prod2 = 64'(prod1_r) * 64'(dt_r);

  // record distance times 240000, as 15 * (2^14 - 2^8 - 2^7)
  always_comb begin
    rec_x15 = (ACC_W'(item_r.record_distance_mm) << 4) - ACC_W'(item_r.record_distance_mm);
    rec_acc = (rec_x15 << 14) - (rec_x15 << 8) - (rec_x15 << 7);
  end

  always_comb begin
    acc_sum = (ACC_W+1)'(acc_r) + (ACC_W+1)'(delta_r);
    if (neg_r) begin
      acc_upd = (delta_r > acc_r) ? '0 : acc_r - delta_r;
    end else begin
      acc_upd = (acc_sum > (ACC_W+1)'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
    end
  end

  // two quotient bits a step; remainder stays below the divisor
  always_comb begin
    trial = {rem_r, dvd_r[DIST_W-1 -: 2]};
    if (trial >= 20'(3 * 240000)) begin
      qbits   = 2'd3;
      rem_nxt = REM_W'(trial - 20'(3 * 240000));
    end else if (trial >= 20'(2 * 240000)) begin
      qbits   = 2'd2;
      rem_nxt = REM_W'(trial - 20'(2 * 240000));
    end else if (trial >= 20'(MM_DIVISOR)) begin
      qbits   = 2'd1;
      rem_nxt = REM_W'(trial - 20'(MM_DIVISOR));
    end else begin
      qbits   = 2'd0;
      rem_nxt = REM_W'(trial);
    end
  end

  always_comb begin
    is_upd     = (item_r.opcode == OP_UPDATE);
    ready      = item_r.drive_ready;
    since_save = item_r.time_ms - last_save_r;
    do_save    = is_upd && (ready ? (since_save >= interval_r) : was_ready_r);
    take       = !is_upd && (item_r.record_distance_mm < DIST_LIMIT)
                 && (!found_r || (item_r.record_sequence > seq_cnt_r));
    slot_inc   = (slot_r == SLOT_W'(NUM_SLOTS - 1)) ? '0 : slot_r + 1'b1;

    if (is_upd && ready) begin
      dist_nxt = quo_r;
    end else if (take) begin
      dist_nxt = item_r.record_distance_mm;
    end else begin
      dist_nxt = dist_r;
    end

    if (take) begin
      slot_nxt = slot_mod(item_r.record_slot);
    end else if (do_save) begin
      slot_nxt = slot_inc;
    end else begin
      slot_nxt = slot_r;
    end

    if (cmd.acc) begin
      acc_nxt = acc_upd;
    end else if (cmd.finish && take) begin
      acc_nxt = rec_acc;
    end else begin
      acc_nxt = acc_r;
    end

    out_word_nxt.save_request      = do_save;
    out_word_nxt.save_slot         = do_save ? 3'(slot_inc) : 3'd0;
    out_word_nxt.save_sequence     = do_save ? seq_cnt_r + 1'b1 : '0;
    out_word_nxt.save_distance_mm  = do_save ? dist_nxt : '0;
    out_word_nxt.total_distance_mm = dist_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      circ_r        <= CIRC_RESET;
      interval_r    <= INTERVAL_RESET;
      was_ready_r   <= 1'b0;
      last_update_r <= '0;
      last_save_r   <= '0;
      acc_r         <= '0;
      slot_r        <= '0;
      seq_cnt_r     <= '0;
      found_r       <= 1'b0;
      dist_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_CIRC:     circ_r     <= cfg_wdata[CIRC_W-1:0];
          REG_INTERVAL: interval_r <= cfg_wdata[TIME_W-1:0];
          default: ;
        endcase
      end
      acc_r <= acc_nxt;
      if (cmd.finish) begin
        dist_r <= dist_nxt;
        slot_r <= slot_nxt;
        if (is_upd) begin
          was_ready_r <= ready;
          if (ready) begin
            last_update_r <= item_r.time_ms;
          end
          if (do_save) begin
            seq_cnt_r   <= seq_cnt_r + 1'b1;
            last_save_r <= item_r.time_ms;
          end
        end else if (take) begin
          seq_cnt_r <= item_r.record_sequence;
          found_r   <= 1'b1;
        end
      end
      out_valid_r <= cmd.finish || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_word;
    end
    if (cmd.mul1) begin
      neg_r   <= rpm_sum[RPM_SUM_W-1];
      prod1_r <= 32'(mag) * 32'(circ_r);
      dt_r    <= was_ready_r ? item_r.time_ms - last_update_r : '0;
    end
    if (cmd.mul2) begin
      delta_r <= (prod2 > 64'(ACC_MAX)) ? ACC_MAX : prod2[ACC_W-1:0];
    end
    if (cmd.acc) begin
      rem_r <= acc_upd[ACC_W-1 -: REM_W];
      dvd_r <= acc_upd[DIST_W-1:0];
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DIST_W-3:0], 2'b00};
      quo_r <= {quo_r[DIST_W-3:0], qbits};
    end
    if (cmd.finish) begin
      out_word_r <= out_word_nxt;
    end
  end

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= ACC_MAX)
    else $error("accumulator above saturation limit");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    9'(slot_r) < 9'(NUM_SLOTS))
    else $error("slot pointer out of range");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.save_request) |->
      (out_word_r.save_slot == 3'd0 && out_word_r.save_sequence == '0
       && out_word_r.save_distance_mm == '0))
    else $error("save fields set without a save request");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.total_distance_mm < DIST_LIMIT))
    else $error("reported distance out of range");

endmodule

### tb/testbench.sv
// Self-checking testbench for the odometer accumulator with rotating save-slot log.
`timescale 1ns / 1ps

module testbench;
  import odo_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 200;
  localparam int CALM_ITEMS  = 150;
  localparam int DRAIN       = 30;

  // Predicts the word produced for each accepted input word and holds the queue
  // of distance and save words still owed by the core.
  class odo_scoreboard;
    logic [CIRC_W-1:0] circ_mm;
    logic [TIME_W-1:0] interval_ms;
    bit                driving;
    logic [TIME_W-1:0] last_tick_ms;
    logic [TIME_W-1:0] last_save_ms;
    longint unsigned   acc;
    int unsigned       slot_ptr;
    logic [SEQ_W-1:0]  save_count;
    bit                have_record;
    out_word_t         owed[$];
    int                errors;

    function new();
      circ_mm      = CIRC_RESET;
      interval_ms  = INTERVAL_RESET;
      driving      = 1'b0;
      last_tick_ms = '0;
      last_save_ms = '0;
      acc          = 0;
      slot_ptr     = 0;
      save_count   = '0;
      have_record  = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
      if (addr == REG_CIRC) begin
        circ_mm = data[CIRC_W-1:0];
      end else if (addr == REG_INTERVAL) begin
        interval_ms = data[TIME_W-1:0];
      end
    endfunction

    function void add_travel(input int rpm_sum, input logic [TIME_W-1:0] dt);
      longint unsigned limit;
      longint unsigned mag;
      longint unsigned step;
      limit = 64'(ACC_MAX);
      mag   = 64'((rpm_sum < 0) ? -rpm_sum : rpm_sum);
      mag   = mag * 64'(circ_mm);
      if (dt != '0 && mag > limit / 64'(dt)) begin
        step = limit;
      end else begin
        step = mag * 64'(dt);
      end
      if (rpm_sum >= 0) begin
        acc = (step > limit - acc) ? limit : acc + step;
      end else begin
        acc = (step > acc) ? 64'd0 : acc - step;
      end
    endfunction

    function out_word_t save_word();
      out_word_t r;
      r                  = '0;
      save_count         = save_count + 1'b1;
      slot_ptr           = (slot_ptr + 1) % NUM_SLOTS;
      r.save_request     = 1'b1;
      r.save_slot        = 3'(slot_ptr);
      r.save_sequence    = save_count;
      r.save_distance_mm = DIST_W'(acc / 64'(MM_DIVISOR));
      return r;
    endfunction

    function void note_input(input in_word_t w);
      out_word_t         r;
      int                rpm_sum;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] since_save;
      r   = '0;
      now = w.time_ms;
      if (w.opcode == OP_UPDATE) begin
        if (w.drive_ready) begin
          if (!driving) begin
            last_tick_ms = now;
            driving      = 1'b1;
          end
          rpm_sum = int'($signed(w.rpm_front_left)) + int'($signed(w.rpm_front_right))
                  + int'($signed(w.rpm_rear_left)) + int'($signed(w.rpm_rear_right));
          add_travel(rpm_sum, now - last_tick_ms);
          last_tick_ms = now;
          since_save   = now - last_save_ms;
          if (since_save >= interval_ms) begin
            r            = save_word();
            last_save_ms = now;
          end
        end else if (driving) begin
          r            = save_word();
          last_save_ms = now;
          driving      = 1'b0;
        end
      end else if (w.record_distance_mm < DIST_LIMIT) begin
        if (!have_record || w.record_sequence > save_count) begin
          acc         = 64'(w.record_distance_mm) * 64'(MM_DIVISOR);
          save_count  = w.record_sequence;
          slot_ptr    = int'(w.record_slot) % NUM_SLOTS;
          have_record = 1'b1;
        end
      end
      r.total_distance_mm = DIST_W'(acc / 64'(MM_DIVISOR));
      owed.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(input out_word_t got);
      out_word_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word, expected none, actual %p", $time, got);
        return;
      end
      want = owed.pop_front();
      compare_field("save_request", 64'(want.save_request), 64'(got.save_request));
      compare_field("save_slot", 64'(want.save_slot), 64'(got.save_slot));
      compare_field("save_sequence", 64'(want.save_sequence), 64'(got.save_sequence));
      compare_field("save_distance_mm", 64'(want.save_distance_mm),
                    64'(got.save_distance_mm));
      compare_field("total_distance_mm", 64'(want.total_distance_mm),
                    64'(got.total_distance_mm));
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_word_t              in_word   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_stall;
  logic                  out_valid;
  out_word_t             out_word;

  bit                calm     = 1'b0;
  bit                drive_on = 1'b0;
  logic [TIME_W-1:0] clock_ms = '0;
  int                cycles   = 0;
  odo_scoreboard     sb;

  odometer_accumulator_with_slot_log_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else if (rst_n) begin
      if (cfg_we) begin
        sb.write_reg(cfg_addr, cfg_wdata);
      end
      if (in_valid && !in_stall) begin
        sb.note_input(in_word);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_word);
      end
    end
  end

  // Receiver back-pressure in bursts
  initial begin
    int n;
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 16);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic in_word_t noise_word();
    logic [191:0] bits_r;
    in_word_t     w;
    bits_r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w      = bits_r[$bits(in_word_t)-1:0];
    return w;
  endfunction

  function automatic in_word_t update_word(input logic [TIME_W-1:0] t, input bit rdy,
                                           input logic [15:0] fl, input logic [15:0] fr,
                                           input logic [15:0] rl, input logic [15:0] rr);
    in_word_t w;
    w                 = noise_word();
    w.opcode          = OP_UPDATE;
    w.time_ms         = t;
    w.drive_ready     = rdy;
    w.rpm_front_left  = fl;
    w.rpm_front_right = fr;
    w.rpm_rear_left   = rl;
    w.rpm_rear_right  = rr;
    return w;
  endfunction

  function automatic in_word_t record_word(input logic [2:0] slot,
                                           input logic [DIST_W-1:0] rec_mm,
                                           input logic [SEQ_W-1:0] seq);
    in_word_t w;
    w                    = noise_word();
    w.opcode             = OP_RECORD;
    w.record_slot        = slot;
    w.record_distance_mm = rec_mm;
    w.record_sequence    = seq;
    return w;
  endfunction

  function automatic logic [15:0] rand_rpm();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'(-int'($urandom_range(0, 20000)));
      2: return ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 6000));
    endcase
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the sender off until every owed word has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic directed_words();
    send_word(update_word(32'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
    send_word(record_word(3'd3, 40'd1000000000000, 32'd7));
    send_word(record_word(3'd3, 40'hff_ffff_ffff, 32'd7));
    send_word(record_word(3'd7, 40'd999999999999, 32'd5));
    send_word(record_word(3'd1, 40'd10, 32'd3));
    send_word(record_word(3'd2, 40'd1000, 32'd9));
    // entering ready adds nothing
    send_word(update_word(32'd100, 1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_word(update_word(32'd200, 1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    // saturates and saves
    send_word(update_word(32'hffff_ff00, 1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_word(update_word(32'hffff_ff00, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0));
    // time wraps
    send_word(update_word(32'h0000_0040, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    // floors at zero
    send_word(update_word(32'h7000_0000, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_word(update_word(32'h7000_0010, 1'b1, 16'd20000, -16'sd20000, 16'd5, -16'sd3));
    send_word(update_word(32'h7000_0020, 1'b0, 16'd100, 16'd100, 16'd100, 16'd100));
    send_word(update_word(32'h7000_0030, 1'b0, 16'd100, 16'd100, 16'd100, 16'd100));
    send_word(record_word(3'd5, 40'd12345, 32'hffff_ffff));
    send_word(update_word(32'h7000_0040, 1'b1, 16'd1000, 16'd1000, 16'd1000, 16'd1000));
    // sequence wraps to zero
    send_word(update_word(32'h7004_93e0, 1'b1, 16'd1000, 16'd1000, 16'd1000, 16'd1000));
    send_word(update_word(32'h7004_93e1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
    send_word(record_word(3'd4, 40'd0, 32'd10));
    send_word(update_word(32'hffff_ffff, 1'b1, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    send_word(update_word(32'h0000_0000, 1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
  endtask

  task automatic run_phase(input logic [CIRC_W-1:0] circ, input logic [TIME_W-1:0] interval,
                           input bit last_phase);
    in_word_t          w;
    logic [DIST_W-1:0] rec_mm;
    logic [SEQ_W-1:0]  seq;
    int                sel;
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_CIRC;
    cfg_wdata <= CFG_DATA_W'(circ);
    @(posedge clk);
    cfg_addr  <= REG_INTERVAL;
    cfg_wdata <= interval;
    @(posedge clk);
    cfg_we    <= 1'b0;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (last_phase && k == PHASE_ITEMS - CALM_ITEMS) begin
        calm = 1'b1;
      end
      sel = $urandom_range(0, 99);
      w   = noise_word();
      if (sel < 75) begin
        if ($urandom_range(0, 11) == 0) begin
          drive_on = !drive_on;
        end
        clock_ms = clock_ms + (($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 40));
        w = update_word(clock_ms, drive_on, rand_rpm(), rand_rpm(), rand_rpm(), rand_rpm());
      end else if (sel < 88) begin
        case ($urandom_range(0, 5))
          0: rec_mm = DIST_LIMIT + 40'($urandom);
          1: rec_mm = 40'({$urandom, $urandom});
          2: rec_mm = DIST_LIMIT - 40'd1 - 40'($urandom_range(0, 1000));
          3: rec_mm = 40'($urandom_range(0, 100000));
          default: rec_mm = 40'(64'({$urandom, $urandom}) % 64'(DIST_LIMIT));
        endcase
        seq = ($urandom_range(0, 1) == 1) ? sb.save_count + 32'($urandom_range(0, 3))
                                          : 32'($urandom);
        w = record_word(3'($urandom), rec_mm, seq);
      end
      send_word(w);
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_words();
    run_phase(14'd1600, 32'd300000, 1'b0);
    run_phase(14'd10000, 32'd50, 1'b0);
    run_phase(14'd1, 32'd1, 1'b0);
    run_phase(14'd16383, 32'd0, 1'b0);
    run_phase(14'd0, 32'd20, 1'b0);
    run_phase(14'd2000, 32'hffff_ffff, 1'b0);
    run_phase(14'd777, 32'd200, 1'b1);
    settle();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/odo_pkg.sv
rtl/core/odo_ctrl.sv
rtl/core/odo_dpath.sv
rtl/core/odometer_accumulator_with_slot_log_core.sv
tb/testbench.sv
